[rtl/qta_pkg.sv]
// shared constants, codes and helpers for the quadtree tile allocator
`timescale 1ns / 1ps
package qta_pkg;

  localparam int ATLAS_SIZE_DEF    = 2048;
  localparam int LARGEST_TILE_DEF  = 512;
  localparam int SMALLEST_TILE_DEF = 64;
  localparam int STACK_DEPTH_DEF   = 1024;

  localparam int MAX_LEVELS = 16;
  localparam int LEVEL_W    = 4;
  localparam int MODE_W     = 2;
  localparam int SIZE_W     = 12;
  localparam int COORD_W    = 11;
  localparam int STATUS_W   = 2;
  localparam int OSIZE_W    = 10;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR   = 2'd0,
    MODE_ALLOC   = 2'd1,
    MODE_RELEASE = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_BAD_SIZE = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic               ok;
    logic [LEVEL_W-1:0] level;
  } level_info_t;

  function automatic int level_total(input int largest, input int smallest);
    int s;
    int n;
    s = largest;
    n = 1;
    while (s > smallest && s > 1 && n < MAX_LEVELS) begin
      s = s / 2;
      n = n + 1;
    end
    return n;
  endfunction

endpackage

[rtl/qta_corner_ram.sv]
// single write, single registered read memory holding free tile corners
`timescale 1ns / 1ps
module qta_corner_ram #(
  parameter int AW = 12,
  parameter int DW = 22
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/qta_level_decode.sv]
// maps a tile edge to its size level and flags edges that are not allowed
`timescale 1ns / 1ps
module qta_level_decode #(
  parameter int LARGEST_TILE  = qta_pkg::LARGEST_TILE_DEF,
  parameter int SMALLEST_TILE = qta_pkg::SMALLEST_TILE_DEF
) (
  input  logic [qta_pkg::SIZE_W-1:0] tile_size,
  output qta_pkg::level_info_t       info
);
  import qta_pkg::*;

  localparam int NLEV = level_total(LARGEST_TILE, SMALLEST_TILE);

  logic [31:0] size_ext;

  assign size_ext = 32'(tile_size);

  always_comb begin
    info.ok    = 1'b0;
    info.level = '0;
    for (int l = 0; l < NLEV; l++) begin
      if (size_ext == 32'(LARGEST_TILE >> l) && size_ext >= 32'(SMALLEST_TILE)) begin
        info.ok    = 1'b1;
        info.level = LEVEL_W'(l);
      end
    end
  end

endmodule

[rtl/quadtree_tile_allocator.sv]
// quadtree tile allocator top level: sequencer, free stack counts and result register
`timescale 1ns / 1ps
// Hands out square power-of-two tiles from a square atlas, one request at a time.
// in_ready is high only while the sequencer is idle; one result per request is held
// in an output register, so a request can be taken while the last result waits.
// The corner memory does one write and one read per cycle. A clear loads
// min(atlas tiles, STACK_DEPTH) largest tiles; an allocate searches the levels,
// loads a corner and pushes three corners per split; an allocate that finds no
// space or no room for its splits ends after the search; a release pushes the
// corner unless its stack is full; a bad size or an unused mode goes straight
// to the result.
// Free stacks are empty after reset and need no clearing pass.
module quadtree_tile_allocator #(
  parameter int ATLAS_SIZE    = qta_pkg::ATLAS_SIZE_DEF,
  parameter int LARGEST_TILE  = qta_pkg::LARGEST_TILE_DEF,
  parameter int SMALLEST_TILE = qta_pkg::SMALLEST_TILE_DEF,
  parameter int STACK_DEPTH   = qta_pkg::STACK_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [qta_pkg::MODE_W-1:0]   mode,
  input  logic [qta_pkg::SIZE_W-1:0]   tile_size,
  input  logic [qta_pkg::COORD_W-1:0]  tile_x,
  input  logic [qta_pkg::COORD_W-1:0]  tile_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [qta_pkg::STATUS_W-1:0] status,
  output logic [qta_pkg::COORD_W-1:0]  out_x,
  output logic [qta_pkg::COORD_W-1:0]  out_y,
  output logic [qta_pkg::OSIZE_W-1:0]  out_size
);
  import qta_pkg::*;

  localparam int NLEV     = level_total(LARGEST_TILE, SMALLEST_TILE);
  localparam int LW       = (NLEV > 1) ? $clog2(NLEV) : 1;
  localparam int IW       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNTW     = $clog2(STACK_DEPTH + 1);
  localparam int AW       = LW + IW;
  localparam int DW       = 2 * COORD_W;
  localparam int TW       = $clog2(LARGEST_TILE) + 1;
  localparam int PER_ROW  = ATLAS_SIZE / LARGEST_TILE;
  localparam int PR_SAFE  = (PER_ROW > 0) ? PER_ROW : 1;
  localparam int TOTAL    = PER_ROW * PER_ROW;
  localparam int KEEP     = (TOTAL > STACK_DEPTH) ? STACK_DEPTH : TOTAL;
  localparam int CW       = (PR_SAFE > 1) ? $clog2(PR_SAFE) : 1;
  localparam int START_ID = (KEEP > 0) ? KEEP - 1 : 0;
  localparam int START_C  = START_ID % PR_SAFE;
  localparam int START_R  = START_ID / PR_SAFE;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_CLEAR   = 7'b0000010,
    S_SEARCH  = 7'b0000100,
    S_LOAD    = 7'b0001000,
    S_SPLIT   = 7'b0010000,
    S_RELEASE = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_t;

  state_t state;

  logic [CNTW-1:0]     count [NLEV];
  logic [LW-1:0]       lvl;
  logic [LW-1:0]       wanted;
  logic [1:0]          phase;
  logic [TW-1:0]       half;
  logic [IW-1:0]       clr_idx;
  logic [CW-1:0]       clr_col;
  logic [CW-1:0]       clr_row;
  logic [COORD_W-1:0]  tx;
  logic [COORD_W-1:0]  ty;
  logic [STATUS_W-1:0] res_status;
  logic [COORD_W-1:0]  res_x;
  logic [COORD_W-1:0]  res_y;
  logic [OSIZE_W-1:0]  res_size;

  level_info_t         info;
  logic [CNTW-1:0]     cnt_cur;
  logic [COORD_W-1:0]  tx_h;
  logic [COORD_W-1:0]  ty_h;
  logic [COORD_W-1:0]  clr_x;
  logic [COORD_W-1:0]  clr_y;
  logic                room;

  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [DW-1:0]       wr_data;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic [DW-1:0]       rd_data;

  qta_level_decode #(
    .LARGEST_TILE  (LARGEST_TILE),
    .SMALLEST_TILE (SMALLEST_TILE)
  ) u_decode (
    .tile_size (tile_size),
    .info      (info)
  );

  qta_corner_ram #(
    .AW (AW),
    .DW (DW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_ready = (state == S_IDLE);
  assign cnt_cur  = count[lvl];
  assign tx_h     = tx + COORD_W'(half);
  assign ty_h     = ty + COORD_W'(half);
  assign clr_x    = COORD_W'(32'(clr_col) * LARGEST_TILE);
  assign clr_y    = COORD_W'(32'(clr_row) * LARGEST_TILE);

  // every level the splits push to needs room for three corners
  always_comb begin
    room = 1'b1;
    for (int l = 0; l < NLEV; l++) begin
      if (LW'(l) > lvl && LW'(l) <= wanted && count[l] > CNTW'(STACK_DEPTH - 3)) begin
        room = 1'b0;
      end
    end
  end

  // corner memory port control
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {lvl, IW'(cnt_cur)};
    wr_data = {tx, ty};
    rd_en   = 1'b0;
    rd_addr = {lvl, IW'(cnt_cur - CNTW'(1))};
    unique case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = {LW'(0), clr_idx};
        wr_data = {clr_x, clr_y};
      end
      S_SPLIT: begin
        wr_en = 1'b1;
        case (phase)
          2'd0:    wr_data = {tx_h, ty_h};
          2'd1:    wr_data = {tx, ty_h};
          default: wr_data = {tx_h, ty};
        endcase
      end
      S_RELEASE: begin
        wr_en = (cnt_cur < CNTW'(STACK_DEPTH));
      end
      S_SEARCH: begin
        rd_en = (cnt_cur != '0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      for (int l = 0; l < NLEV; l++) begin
        count[l] <= '0;
      end
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            res_x      <= '0;
            res_y      <= '0;
            res_size   <= '0;
            tx         <= tile_x;
            ty         <= tile_y;
            lvl        <= LW'(info.level);
            wanted     <= LW'(info.level);
            phase      <= '0;
            case (mode)
              MODE_CLEAR: begin
                for (int l = 0; l < NLEV; l++) begin
                  count[l] <= '0;
                end
                clr_idx    <= '0;
                clr_col    <= CW'(START_C);
                clr_row    <= CW'(START_R);
                res_status <= (KEEP < TOTAL) ? ST_FULL : ST_OK;
                state      <= (KEEP > 0) ? S_CLEAR : S_DONE;
              end
              MODE_ALLOC: begin
                if (!info.ok) begin
                  res_status <= ST_BAD_SIZE;
                  state      <= S_DONE;
                end else begin
                  res_status <= ST_OK;
                  state      <= S_SEARCH;
                end
              end
              MODE_RELEASE: begin
                if (!info.ok) begin
                  res_status <= ST_BAD_SIZE;
                  state      <= S_DONE;
                end else begin
                  res_status <= ST_OK;
                  state      <= S_RELEASE;
                end
              end
              default: begin
                res_status <= ST_OK;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_CLEAR: begin
          count[0] <= CNTW'({1'b0, clr_idx} + (IW + 1)'(1));
          clr_idx  <= clr_idx + IW'(1);
          if (clr_col == '0) begin
            clr_col <= CW'(PR_SAFE - 1);
            clr_row <= clr_row - CW'(1);
          end else begin
            clr_col <= clr_col - CW'(1);
          end
          if ({1'b0, clr_idx} == (IW + 1)'(START_ID)) begin
            state <= S_DONE;
          end
        end
        S_SEARCH: begin
          if (cnt_cur != '0) begin
            if (!room) begin
              res_status <= ST_FULL;
              state      <= S_DONE;
            end else begin
              count[lvl] <= cnt_cur - CNTW'(1);
              state      <= S_LOAD;
            end
          end else if (lvl == '0) begin
            res_status <= ST_NO_SPACE;
            state      <= S_DONE;
          end else begin
            lvl <= lvl - LW'(1);
          end
        end
        S_LOAD: begin
          tx       <= rd_data[DW-1:COORD_W];
          ty       <= rd_data[COORD_W-1:0];
          res_x    <= rd_data[DW-1:COORD_W];
          res_y    <= rd_data[COORD_W-1:0];
          res_size <= OSIZE_W'(LARGEST_TILE >> wanted);
          half     <= TW'(LARGEST_TILE >> (lvl + LW'(1)));
          lvl      <= lvl + LW'(1);
          state    <= (lvl == wanted) ? S_DONE : S_SPLIT;
        end
        S_SPLIT: begin
          count[lvl] <= cnt_cur + CNTW'(1);
          if (phase == 2'd2) begin
            phase <= '0;
            if (lvl == wanted) begin
              state <= S_DONE;
            end else begin
              lvl  <= lvl + LW'(1);
              half <= half >> 1;
            end
          end else begin
            phase <= phase + 2'd1;
          end
        end
        S_RELEASE: begin
          if (cnt_cur < CNTW'(STACK_DEPTH)) begin
            count[lvl] <= cnt_cur + CNTW'(1);
          end else begin
            res_status <= ST_FULL;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            status    <= res_status;
            out_x     <= res_x;
            out_y     <= res_y;
            out_size  <= res_size;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
